### rtl/core/mpa_pkg.sv
// Shared constants, register codes and flag structs of the max pooling block.
// Used by every module of the block; depends on nothing.
package mpa_pkg;

    // Default sizing of the block
    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_MAP_WIDTH = 256;
    localparam int MAX_WINDOW    = 8;

    // Fixed field and register widths
    localparam int OFFSET_BITS      = 3;
    localparam int WINDOW_SIZE_BITS = 4;
    localparam int MAP_WIDTH_BITS   = 9;
    localparam int MAP_COUNT_BITS   = 9;
    localparam int CFG_DATA_BITS    = 9;
    localparam int CFG_INDEX_BITS   = 2;

    // Map index within a batch
    localparam int MAP_CTR_BITS = 8;
    localparam int MAX_MAPS     = 256;

    // Register values after reset
    localparam int WINDOW_SIZE_RESET = 2;
    localparam int MAP_WIDTH_RESET   = 28;
    localparam int MAP_COUNT_RESET   = 1;

    // Result queue
    localparam int FIFO_DEPTH    = 3;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WINDOW_SIZE = 2'd0,
        CFG_MAP_WIDTH   = 2'd1,
        CFG_MAP_COUNT   = 2'd2
    } cfg_index_t;

    // Position flags of one accepted pixel
    typedef struct packed {
        logic in_range;   // pixel lies in a whole window
        logic first;      // first pixel of its window
        logic last;       // last pixel of its window
        logic map_end;    // last window of the map
        logic batch_end;  // last window of the last map
    } pix_flags_t;

    // End markers of one result word
    typedef struct packed {
        logic map_done;
        logic batch_done;
    } res_flags_t;

endpackage

### rtl/core/mpa_pos_ctrl.sv
// Configuration registers, raster position counters and window position tracking.
// Recomputes window offsets by serial division after reset and register writes; uses mpa_pkg.
module mpa_pos_ctrl #(
    parameter int MAX_MAP_WIDTH = mpa_pkg::MAX_MAP_WIDTH,
    parameter int MAX_WINDOW    = mpa_pkg::MAX_WINDOW,
    localparam int CNT_W  = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1,
    localparam int WOFF_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_write,
    input  logic [mpa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mpa_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 advance,
    output logic                                 busy,
    output logic [CNT_W-1:0]                     rd_addr,
    output logic [WOFF_W-1:0]                    win_row,
    output logic [WOFF_W-1:0]                    win_col,
    output mpa_pkg::pix_flags_t                  flags
);

    localparam int DIV_W  = CNT_W + 1;
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int STEP_W = $clog2(DIV_W + 1);
    localparam int NDIV   = 3;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIVIDE,
        ST_READY
    } state_t;

    state_t state_reg;
    logic [STEP_W-1:0] step_reg;

    logic [mpa_pkg::WINDOW_SIZE_BITS-1:0] window_size_reg;
    logic [mpa_pkg::MAP_WIDTH_BITS-1:0]   map_width_reg;
    logic [mpa_pkg::MAP_COUNT_BITS-1:0]   map_count_reg;

    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  row_reg;
    logic [WOFF_W-1:0] wcol_reg;
    logic [WOFF_W-1:0] wrow_reg;
    logic [CNT_W-1:0]  ocol_reg;
    logic [CNT_W-1:0]  orow_reg;
    logic [DIV_W-1:0]  nwin_reg;
    logic [mpa_pkg::MAP_CTR_BITS-1:0] map_reg;

    logic [DIV_W-1:0] dvd_reg  [NDIV];
    logic [WIN_W-1:0] rem_reg  [NDIV];
    logic [DIV_W-1:0] dvd_next [NDIV];
    logic [WIN_W-1:0] rem_next [NDIV];
    logic [WIN_W:0]   trial    [NDIV];
    logic [WIN_W-1:0] dsr_reg;

    logic [WIN_W-1:0]                   k;
    logic [DIV_W-1:0]                   w;
    logic [mpa_pkg::MAP_COUNT_BITS-1:0] m;

    logic [WIN_W-1:0] k_m1;
    logic [DIV_W-1:0] nwin_m1;
    logic [WIN_W-1:0] wcol_inc;
    logic [WIN_W-1:0] wrow_inc;
    logic             col_wrap;
    logic             row_wrap;
    logic             map_wrap;

    // Clamp registers into their working ranges
    always_comb begin
        if (window_size_reg == '0) begin
            k = WIN_W'(1);
        end else if (int'(window_size_reg) > MAX_WINDOW) begin
            k = WIN_W'(MAX_WINDOW);
        end else begin
            k = WIN_W'(window_size_reg);
        end
        if (map_width_reg == '0) begin
            w = DIV_W'(1);
        end else if (int'(map_width_reg) > MAX_MAP_WIDTH) begin
            w = DIV_W'(MAX_MAP_WIDTH);
        end else begin
            w = DIV_W'(map_width_reg);
        end
        if (map_count_reg == '0) begin
            m = mpa_pkg::MAP_COUNT_BITS'(1);
        end else if (int'(map_count_reg) > mpa_pkg::MAX_MAPS) begin
            m = mpa_pkg::MAP_COUNT_BITS'(mpa_pkg::MAX_MAPS);
        end else begin
            m = map_count_reg;
        end
    end

    // One restoring division step on column, row and width in parallel
    always_comb begin
        for (int i = 0; i < NDIV; i++) begin
            trial[i] = {rem_reg[i], dvd_reg[i][DIV_W-1]};
            if (trial[i] >= {1'b0, dsr_reg}) begin
                rem_next[i] = WIN_W'(trial[i] - {1'b0, dsr_reg});
                dvd_next[i] = {dvd_reg[i][DIV_W-2:0], 1'b1};
            end else begin
                rem_next[i] = WIN_W'(trial[i]);
                dvd_next[i] = {dvd_reg[i][DIV_W-2:0], 1'b0};
            end
        end
    end

    // Wrap conditions of the position counters
    assign wcol_inc = WIN_W'(wcol_reg) + WIN_W'(1);
    assign wrow_inc = WIN_W'(wrow_reg) + WIN_W'(1);
    assign col_wrap = ({1'b0, col_reg} + DIV_W'(1)) >= w;
    assign row_wrap = ({1'b0, row_reg} + DIV_W'(1)) >= w;
    assign map_wrap = (mpa_pkg::MAP_COUNT_BITS'(map_reg) + mpa_pkg::MAP_COUNT_BITS'(1)) >= m;

    // Classify the pixel at the current position
    assign k_m1    = k - WIN_W'(1);
    assign nwin_m1 = nwin_reg - DIV_W'(1);
    always_comb begin
        flags.in_range  = ({1'b0, ocol_reg} < nwin_reg) && ({1'b0, orow_reg} < nwin_reg);
        flags.first     = (wcol_reg == '0) && (wrow_reg == '0);
        flags.last      = (WIN_W'(wcol_reg) == k_m1) && (WIN_W'(wrow_reg) == k_m1);
        flags.map_end   = flags.last && ({1'b0, ocol_reg} == nwin_m1)
                          && ({1'b0, orow_reg} == nwin_m1);
        flags.batch_end = flags.map_end && map_wrap;
    end

    assign busy    = (state_reg != ST_READY);
    assign rd_addr = ocol_reg;
    assign win_row = wrow_reg;
    assign win_col = wcol_reg;

    // Hold registers, sequence the divider, advance the position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            step_reg        <= '0;
            window_size_reg <= mpa_pkg::WINDOW_SIZE_BITS'(mpa_pkg::WINDOW_SIZE_RESET);
            map_width_reg   <= mpa_pkg::MAP_WIDTH_BITS'(mpa_pkg::MAP_WIDTH_RESET);
            map_count_reg   <= mpa_pkg::MAP_COUNT_BITS'(mpa_pkg::MAP_COUNT_RESET);
            col_reg         <= '0;
            row_reg         <= '0;
            wcol_reg        <= '0;
            wrow_reg        <= '0;
            ocol_reg        <= '0;
            orow_reg        <= '0;
            nwin_reg        <= '0;
            map_reg         <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                mpa_pkg::CFG_WINDOW_SIZE: begin
                    window_size_reg <= cfg_data[mpa_pkg::WINDOW_SIZE_BITS-1:0];
                end
                mpa_pkg::CFG_MAP_WIDTH: begin
                    map_width_reg <= cfg_data[mpa_pkg::MAP_WIDTH_BITS-1:0];
                end
                mpa_pkg::CFG_MAP_COUNT: begin
                    map_count_reg <= cfg_data[mpa_pkg::MAP_COUNT_BITS-1:0];
                end
                default: begin
                end
            endcase
            state_reg <= ST_LOAD;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    dvd_reg[0] <= {1'b0, col_reg};
                    dvd_reg[1] <= {1'b0, row_reg};
                    dvd_reg[2] <= w;
                    for (int i = 0; i < NDIV; i++) begin
                        rem_reg[i] <= '0;
                    end
                    dsr_reg   <= k;
                    step_reg  <= '0;
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    for (int i = 0; i < NDIV; i++) begin
                        dvd_reg[i] <= dvd_next[i];
                        rem_reg[i] <= rem_next[i];
                    end
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_W - 1)) begin
                        ocol_reg  <= CNT_W'(dvd_next[0]);
                        wcol_reg  <= WOFF_W'(rem_next[0]);
                        orow_reg  <= CNT_W'(dvd_next[1]);
                        wrow_reg  <= WOFF_W'(rem_next[1]);
                        nwin_reg  <= dvd_next[2];
                        state_reg <= ST_READY;
                    end
                end
                ST_READY: begin
                    if (advance) begin
                        if (col_wrap) begin
                            col_reg  <= '0;
                            wcol_reg <= '0;
                            ocol_reg <= '0;
                            if (row_wrap) begin
                                row_reg  <= '0;
                                wrow_reg <= '0;
                                orow_reg <= '0;
                                map_reg  <= map_wrap ? '0
                                                     : map_reg + mpa_pkg::MAP_CTR_BITS'(1);
                            end else begin
                                row_reg <= row_reg + CNT_W'(1);
                                if (wrow_inc >= k) begin
                                    wrow_reg <= '0;
                                    orow_reg <= orow_reg + CNT_W'(1);
                                end else begin
                                    wrow_reg <= WOFF_W'(wrow_inc);
                                end
                            end
                        end else begin
                            col_reg <= col_reg + CNT_W'(1);
                            if (wcol_inc >= k) begin
                                wcol_reg <= '0;
                                ocol_reg <= ocol_reg + CNT_W'(1);
                            end else begin
                                wcol_reg <= WOFF_W'(wcol_inc);
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

### rtl/core/mpa_col_store.sv
// Per-column running maximum memory with read-modify-write and write forwarding.
// Reads at accept, compares and writes back in the following cycle; uses mpa_pkg.
module mpa_col_store #(
    parameter int MAX_MAP_WIDTH = mpa_pkg::MAX_MAP_WIDTH,
    parameter int MAX_WINDOW    = mpa_pkg::MAX_WINDOW,
    parameter int SAMPLE_BITS   = mpa_pkg::SAMPLE_BITS,
    localparam int CNT_W  = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1,
    localparam int WOFF_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               accept,
    input  logic signed [SAMPLE_BITS-1:0]      pixel,
    input  logic [CNT_W-1:0]                   rd_addr,
    input  logic [WOFF_W-1:0]                  win_row,
    input  logic [WOFF_W-1:0]                  win_col,
    input  mpa_pkg::pix_flags_t                flags,
    output logic                               push,
    output logic signed [SAMPLE_BITS-1:0]      res_value,
    output logic [mpa_pkg::OFFSET_BITS-1:0]    res_row,
    output logic [mpa_pkg::OFFSET_BITS-1:0]    res_col,
    output mpa_pkg::res_flags_t                res_flags
);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic [WOFF_W-1:0]             arg_row;
        logic [WOFF_W-1:0]             arg_col;
    } entry_t;

    entry_t mem [MAX_MAP_WIDTH];
    entry_t rd_data_reg;
    entry_t fwd_data_reg;
    logic   fwd_hit_reg;

    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_pixel_reg;
    logic [CNT_W-1:0]              s1_addr_reg;
    logic [WOFF_W-1:0]             s1_row_reg;
    logic [WOFF_W-1:0]             s1_col_reg;
    mpa_pkg::pix_flags_t           s1_flags_reg;

    entry_t cur;
    entry_t upd;
    logic   wr_en;

    // Pick the forwarded entry when the previous word wrote the same column
    assign cur = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    // Restart on a window's first pixel, replace only on a strictly greater sample
    always_comb begin
        if (s1_flags_reg.first) begin
            upd.value   = s1_pixel_reg;
            upd.arg_row = '0;
            upd.arg_col = '0;
        end else if ($signed(s1_pixel_reg) > $signed(cur.value)) begin
            upd.value   = s1_pixel_reg;
            upd.arg_row = s1_row_reg;
            upd.arg_col = s1_col_reg;
        end else begin
            upd = cur;
        end
    end

    assign wr_en = s1_valid_reg && s1_flags_reg.in_range;

    // Emit on the window's last pixel
    assign push                 = wr_en && s1_flags_reg.last;
    assign res_value            = upd.value;
    assign res_row              = mpa_pkg::OFFSET_BITS'(upd.arg_row);
    assign res_col              = mpa_pkg::OFFSET_BITS'(upd.arg_col);
    assign res_flags.map_done   = s1_flags_reg.map_end;
    assign res_flags.batch_done = s1_flags_reg.batch_end;

    // Write back the update, read the next column entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[s1_addr_reg] <= upd;
        end
        if (accept) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track the compare stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    // Capture the accepted word and the forwarding match
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg <= pixel;
            s1_addr_reg  <= rd_addr;
            s1_row_reg   <= win_row;
            s1_col_reg   <= win_col;
            s1_flags_reg <= flags;
            fwd_hit_reg  <= wr_en && (s1_addr_reg == rd_addr);
            fwd_data_reg <= upd;
        end
    end

endmodule

### rtl/core/mpa_out_fifo.sv
// Small result queue that decouples the compare stage from the output channel.
// Depth and counter widths come from mpa_pkg.
module mpa_out_fifo #(
    parameter int DATA_W = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  logic [DATA_W-1:0]                   push_data,
    input  logic                                pop,
    output logic                                out_valid,
    output logic [DATA_W-1:0]                   out_data,
    output logic [mpa_pkg::FIFO_CNT_BITS-1:0]   count
);

    localparam int PTR_W = (mpa_pkg::FIFO_PTR_BITS > 0) ? mpa_pkg::FIFO_PTR_BITS : 1;

    logic [DATA_W-1:0]                 entry_reg [mpa_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]                  wr_ptr_reg;
    logic [PTR_W-1:0]                  rd_ptr_reg;
    logic [mpa_pkg::FIFO_CNT_BITS-1:0] count_reg;
    logic                              do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(mpa_pkg::FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && out_valid;

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + mpa_pkg::FIFO_CNT_BITS'(1);
            end else if (do_pop && !push) begin
                count_reg <= count_reg - mpa_pkg::FIFO_CNT_BITS'(1);
            end
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/max_pool_argmax_stream.sv
// Top level of the streaming max pooling block with argmax output.
// Instantiates mpa_pos_ctrl, mpa_col_store and mpa_out_fifo; uses mpa_pkg.
//
// Pixels of square feature maps enter in raster order, one word per cycle while
// s_tready is high, and each completed non-overlapping window yields one word
// with its maximum, the row and column of that maximum inside the window
// (earliest wins on a tie), tlast on the last window of a map and tuser on the
// last window of the batch. Outside the stalls below, the sustained rate is one
// pixel per cycle: each pixel reads its column entry from a registered memory read
// and writes it back the next cycle, with a forwarding register covering
// back-to-back pixels of the same column. A result word is offered on the output
// once its last pixel has passed the compare stage and entered the result queue.
// s_tready drops while the three-word result queue could not take every result
// still in flight, which happens only under output back-pressure. After reset
// and after every register write the window position is rebuilt, while s_tready
// is low, by a load state and a serial divider of CNT_W+1 steps.
// Registers: index 0 window size, 1 map width, 2 map count; write them only
// with no pixel or result in flight.
module max_pool_argmax_stream #(
    parameter int MAX_MAP_WIDTH = mpa_pkg::MAX_MAP_WIDTH,
    parameter int MAX_WINDOW    = mpa_pkg::MAX_WINDOW,
    parameter int SAMPLE_BITS   = mpa_pkg::SAMPLE_BITS
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // pixel_value
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]     s_tdata,
    // pooled_value, max_row_offset, max_col_offset
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [((SAMPLE_BITS + 2 * mpa_pkg::OFFSET_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                         m_tlast,
    // batch_done
    output logic                                         m_tuser,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [mpa_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
    input  logic [mpa_pkg::CFG_DATA_BITS-1:0]            cfg_data
);

    localparam int CNT_W   = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;
    localparam int WOFF_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int OFF_W   = mpa_pkg::OFFSET_BITS;
    localparam int RES_W   = SAMPLE_BITS + 2 * OFF_W;
    localparam int OUT_W   = ((RES_W + 7) / 8) * 8;
    localparam int QDATA_W = RES_W + 2;
    localparam int OCC_W   = mpa_pkg::FIFO_CNT_BITS + 1;

    logic                              cfg_write;
    logic                              accept;
    logic                              busy;
    logic [CNT_W-1:0]                  rd_addr;
    logic [WOFF_W-1:0]                 win_row;
    logic [WOFF_W-1:0]                 win_col;
    mpa_pkg::pix_flags_t               flags;
    logic                              push;
    logic signed [SAMPLE_BITS-1:0]     res_value;
    logic [OFF_W-1:0]                  res_row;
    logic [OFF_W-1:0]                  res_col;
    mpa_pkg::res_flags_t               res_flags;
    logic [QDATA_W-1:0]                q_in;
    logic [QDATA_W-1:0]                q_out;
    logic [mpa_pkg::FIFO_CNT_BITS-1:0] q_count;
    logic [OCC_W-1:0]                  occupancy;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = s_tvalid && s_tready;

    // Take a word only when not busy and the queue has room for every result in flight
    assign occupancy = OCC_W'(q_count) + OCC_W'(push);
    assign s_tready  = !busy && (occupancy < OCC_W'(mpa_pkg::FIFO_DEPTH));

    mpa_pos_ctrl #(
        .MAX_MAP_WIDTH (MAX_MAP_WIDTH),
        .MAX_WINDOW    (MAX_WINDOW)
    ) u_pos_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .busy      (busy),
        .rd_addr   (rd_addr),
        .win_row   (win_row),
        .win_col   (win_col),
        .flags     (flags)
    );

    mpa_col_store #(
        .MAX_MAP_WIDTH (MAX_MAP_WIDTH),
        .MAX_WINDOW    (MAX_WINDOW),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_col_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .pixel     (s_tdata[SAMPLE_BITS-1:0]),
        .rd_addr   (rd_addr),
        .win_row   (win_row),
        .win_col   (win_col),
        .flags     (flags),
        .push      (push),
        .res_value (res_value),
        .res_row   (res_row),
        .res_col   (res_col),
        .res_flags (res_flags)
    );

    // Queue word: end markers over the packed result fields
    assign q_in = {res_flags.batch_done, res_flags.map_done, res_col, res_row, res_value};

    mpa_out_fifo #(
        .DATA_W (QDATA_W)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (q_in),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_data  (q_out),
        .count     (q_count)
    );

    assign m_tdata = OUT_W'(q_out[RES_W-1:0]);
    assign m_tlast = q_out[RES_W];
    assign m_tuser = q_out[RES_W+1];

    // The queue never takes a result while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_count < mpa_pkg::FIFO_CNT_BITS'(mpa_pkg::FIFO_DEPTH)))
        else $error("result pushed into a full queue");

    // A register write stalls the input while the window position is rebuilt
    a_cfg_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_write |=> !s_tready)
        else $error("pixel accepted right after a register write");

    // End of batch always coincides with end of map
    a_batch_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("batch end without map end");

    // A result needs a pixel accepted on the cycle before
    a_push_source: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> $past(accept))
        else $error("result without an accepted pixel");

endmodule

### verif/tb_max_pool_argmax_stream.sv
// Self-checking testbench of max_pool_argmax_stream; depends on mpa_pkg. A directed table, a
// full-width row, random phases; typed rows scored by hand, others by a cycle-free predictor.
module tb_max_pool_argmax_stream;

    localparam int SAMPLE_BITS      = mpa_pkg::SAMPLE_BITS;
    localparam int OFFSET_BITS      = mpa_pkg::OFFSET_BITS;
    localparam int CFG_INDEX_BITS   = mpa_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_BITS    = mpa_pkg::CFG_DATA_BITS;
    localparam int WINDOW_SIZE_BITS = mpa_pkg::WINDOW_SIZE_BITS;
    localparam int MAP_WIDTH_BITS   = mpa_pkg::MAP_WIDTH_BITS;
    localparam int MAP_COUNT_BITS   = mpa_pkg::MAP_COUNT_BITS;
    localparam int MAP_CTR_BITS     = mpa_pkg::MAP_CTR_BITS;
    localparam int MAX_MAP_WIDTH    = mpa_pkg::MAX_MAP_WIDTH;
    localparam int MAX_WINDOW       = mpa_pkg::MAX_WINDOW;
    localparam int MAX_MAPS         = mpa_pkg::MAX_MAPS;

    localparam int IN_BITS      = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int RES_BITS     = ((SAMPLE_BITS + 2 * OFFSET_BITS + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_ITEMS   = 820;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 11;

    // Index that no register answers to
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    // One pooled window as it leaves the block
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic [OFFSET_BITS-1:0] row_off;
        logic [OFFSET_BITS-1:0] col_off;
        logic                   map_done;
        logic                   batch_done;
    } pool_result_t;

    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

    // One row of the directed plan: a pixel word or a register write
    typedef struct packed {
        row_kind_t                 kind;
        logic [SAMPLE_BITS-1:0]    px;
        logic                      typed;
        pool_result_t              hand;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  val;
    } plan_row_t;

    localparam pool_result_t NO_RES = '0;

    // Window size starts at 2; maps of 2x2 give one window per map
    localparam plan_row_t PLAN [32] = '{
        '{ROW_REG,   16'h0000, 1'b0, NO_RES, mpa_pkg::CFG_MAP_COUNT, 9'd2},
        '{ROW_REG,   16'h0000, 1'b0, NO_RES, mpa_pkg::CFG_MAP_WIDTH, 9'd2},
        '{ROW_REG,   16'h0000, 1'b0, NO_RES, CFG_UNUSED, 9'h1FF},
        // all equal: the first pixel keeps the maximum
        '{ROW_PIXEL, 16'h0005, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'h0005, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'h0005, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'h0005, 1'b1, '{16'h0005, 3'd0, 3'd0, 1'b1, 1'b0}, '0, '0},
        // most negative everywhere but the last pixel, batch ends here
        '{ROW_PIXEL, 16'h8000, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'h8000, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'h8000, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'h7FFF, 1'b1, '{16'h7FFF, 3'd1, 3'd1, 1'b1, 1'b1}, '0, '0},
        // later tie at the top value loses
        '{ROW_PIXEL, 16'h8000, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'h7FFF, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'h0000, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'h7FFF, 1'b1, '{16'h7FFF, 3'd0, 3'd1, 1'b1, 1'b0}, '0, '0},
        // negatives around a zero
        '{ROW_PIXEL, 16'hFFFF, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'hFFFE, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'h0000, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'hFFFD, 1'b1, '{16'h0000, 3'd1, 3'd0, 1'b1, 1'b1}, '0, '0},
        // zero registers act as one: every pixel is a whole map and batch
        '{ROW_REG,   16'h0000, 1'b0, NO_RES, mpa_pkg::CFG_WINDOW_SIZE, 9'd0},
        '{ROW_REG,   16'h0000, 1'b0, NO_RES, mpa_pkg::CFG_MAP_WIDTH, 9'd0},
        '{ROW_REG,   16'h0000, 1'b0, NO_RES, mpa_pkg::CFG_MAP_COUNT, 9'd0},
        '{ROW_PIXEL, 16'hAAAA, 1'b1, '{16'hAAAA, 3'd0, 3'd0, 1'b1, 1'b1}, '0, '0},
        '{ROW_PIXEL, 16'h5555, 1'b1, '{16'h5555, 3'd0, 3'd0, 1'b1, 1'b1}, '0, '0},
        // oversized registers saturate; upper data bits of the window write ignored
        '{ROW_REG,   16'h0000, 1'b0, NO_RES, mpa_pkg::CFG_WINDOW_SIZE, 9'h1EF},
        '{ROW_REG,   16'h0000, 1'b0, NO_RES, mpa_pkg::CFG_MAP_WIDTH, 9'h1FF},
        '{ROW_REG,   16'h0000, 1'b0, NO_RES, mpa_pkg::CFG_MAP_COUNT, 9'h1FF},
        '{ROW_PIXEL, 16'h1234, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'hFEDC, 1'b0, NO_RES, '0, '0},
        // window wider than the map: consumed, never pooled
        '{ROW_REG,   16'h0000, 1'b0, NO_RES, mpa_pkg::CFG_MAP_WIDTH, 9'd5},
        '{ROW_PIXEL, 16'h0F0F, 1'b0, NO_RES, '0, '0},
        '{ROW_PIXEL, 16'hF0F0, 1'b0, NO_RES, '0, '0}
    };

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_BITS-1:0]        s_tdata   = '0;   // pixel_value
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [RES_BITS-1:0]       m_tdata;          // pooled_value, max_row_offset, max_col_offset
    logic                      m_tlast;          // map_done
    logic                      m_tuser;          // batch_done
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // Predictor copy of registers and window state
    logic [WINDOW_SIZE_BITS-1:0] win_reg   = WINDOW_SIZE_BITS'(mpa_pkg::WINDOW_SIZE_RESET);
    logic [MAP_WIDTH_BITS-1:0]   width_reg = MAP_WIDTH_BITS'(mpa_pkg::MAP_WIDTH_RESET);
    logic [MAP_COUNT_BITS-1:0]   count_reg = MAP_COUNT_BITS'(mpa_pkg::MAP_COUNT_RESET);
    logic signed [SAMPLE_BITS-1:0] col_peak     [MAX_MAP_WIDTH];
    logic [OFFSET_BITS-1:0]        col_peak_row [MAX_MAP_WIDTH];
    logic [OFFSET_BITS-1:0]        col_peak_col [MAX_MAP_WIDTH];
    logic [7:0]                    pos_col = '0;
    logic [7:0]                    pos_row = '0;
    logic [MAP_CTR_BITS-1:0]       map_idx = '0;

    pool_result_t pending_windows [$];
    pool_result_t head_window;
    int           errors       = 0;
    int           results_seen = 0;
    int           gap_pct      = IDLE_PCT;
    int           hold_left    = 0;
    bit           hold_done    = 1'b0;
    int           cycles       = 0;

    max_pool_argmax_stream i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned clip_reg(input int unsigned v, input int unsigned hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Pool one pixel into its column entry; return 1 when a window completes
    function automatic bit pool_pixel(input logic signed [SAMPLE_BITS-1:0] px,
                                      output pool_result_t res);
        int unsigned k, w, m, full, c, r, wr, wc, oc;
        bit emit;
        k    = clip_reg(int'(win_reg), MAX_WINDOW);
        w    = clip_reg(int'(width_reg), MAX_MAP_WIDTH);
        m    = clip_reg(int'(count_reg), MAX_MAPS);
        full = (w / k) * k;
        c    = pos_col;
        r    = pos_row;
        wc   = c % k;
        wr   = r % k;
        emit = 1'b0;
        res  = '0;
        if (c < full && r < full) begin
            oc = (c / k) % MAX_MAP_WIDTH;
            if (wr == 0 && wc == 0) begin
                col_peak[oc]     = px;
                col_peak_row[oc] = '0;
                col_peak_col[oc] = '0;
            end else if (px > col_peak[oc]) begin
                col_peak[oc]     = px;
                col_peak_row[oc] = OFFSET_BITS'(wr);
                col_peak_col[oc] = OFFSET_BITS'(wc);
            end
            if (wr == k - 1 && wc == k - 1) begin
                res.value      = col_peak[oc];
                res.row_off    = col_peak_row[oc];
                res.col_off    = col_peak_col[oc];
                res.map_done   = (r == full - 1) && (c == full - 1);
                res.batch_done = res.map_done && (int'(map_idx) + 1 >= m);
                emit = 1'b1;
            end
        end
        // Advance the raster position; wrap anything at or past its limit
        if (c + 1 >= w) begin
            pos_col = '0;
            if (r + 1 >= w) begin
                pos_row = '0;
                map_idx = (int'(map_idx) + 1 >= m) ? '0 : map_idx + 1'b1;
            end else begin
                pos_row = 8'(r + 1);
            end
        end else begin
            pos_col = 8'(c + 1);
        end
        return emit;
    endfunction

    // Offer one pixel word with a random gap; on acceptance record what it yields
    task automatic send_pixel(input logic [SAMPLE_BITS-1:0] px, input bit typed,
                              input pool_result_t hand);
        pool_result_t got;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_BITS'(px);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (pool_pixel(px, got) && !typed) pending_windows.push_back(got);
        if (typed) pending_windows.push_back(hand);
        @(negedge aclk);
    endtask

    // Stop offering, wait out every pending result and the pipeline behind it
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_windows.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            mpa_pkg::CFG_WINDOW_SIZE: win_reg   = val[WINDOW_SIZE_BITS-1:0];
            mpa_pkg::CFG_MAP_WIDTH:   width_reg = val[MAP_WIDTH_BITS-1:0];
            mpa_pkg::CFG_MAP_COUNT:   count_reg = val[MAP_COUNT_BITS-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Score each accepted result word against the oldest pending window
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen = results_seen + 1;
            if (pending_windows.size() == 0) begin
                $error("result word with no window pending: tdata %h", m_tdata);
                errors = errors + 1;
            end else begin
                head_window = pending_windows.pop_front();
                if (m_tdata[SAMPLE_BITS-1:0] !== head_window.value) begin
                    $error("pooled_value: expected %0d, got %0d",
                           $signed(head_window.value), $signed(m_tdata[SAMPLE_BITS-1:0]));
                    errors = errors + 1;
                end
                if (m_tdata[SAMPLE_BITS +: OFFSET_BITS] !== head_window.row_off) begin
                    $error("max_row_offset: expected %0d, got %0d",
                           head_window.row_off, m_tdata[SAMPLE_BITS +: OFFSET_BITS]);
                    errors = errors + 1;
                end
                if (m_tdata[SAMPLE_BITS+OFFSET_BITS +: OFFSET_BITS] !== head_window.col_off) begin
                    $error("max_col_offset: expected %0d, got %0d", head_window.col_off,
                           m_tdata[SAMPLE_BITS+OFFSET_BITS +: OFFSET_BITS]);
                    errors = errors + 1;
                end
                if (m_tdata[RES_BITS-1:SAMPLE_BITS+2*OFFSET_BITS] !== '0) begin
                    $error("tdata padding: expected 0, got %h",
                           m_tdata[RES_BITS-1:SAMPLE_BITS+2*OFFSET_BITS]);
                    errors = errors + 1;
                end
                if (m_tlast !== head_window.map_done) begin
                    $error("map_done: expected %0d, got %0d", head_window.map_done, m_tlast);
                    errors = errors + 1;
                end
                if (m_tuser !== head_window.batch_done) begin
                    $error("batch_done: expected %0d, got %0d",
                           head_window.batch_done, m_tuser);
                    errors = errors + 1;
                end
            end
        end
    end

    // Result side: random back-pressure plus one long hold-off to fill the block
    always @(negedge aclk) begin
        if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= gap_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("max_pool_argmax_stream verification failed");
            $finish;
        end
    end

    initial begin
        int unsigned sel, k_raw, k_eff, w_raw, w_eff, m_raw, span, sent;
        logic [SAMPLE_BITS-1:0] px;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed plan
        foreach (PLAN[i]) begin
            if (PLAN[i].kind == ROW_REG) begin
                write_reg(PLAN[i].idx, PLAN[i].val);
            end else begin
                send_pixel(PLAN[i].px, PLAN[i].typed, PLAN[i].hand);
            end
        end

        // Window of one over a full-width row touches every column entry once
        write_reg(mpa_pkg::CFG_WINDOW_SIZE, CFG_DATA_BITS'(1));
        write_reg(mpa_pkg::CFG_MAP_WIDTH, CFG_DATA_BITS'(MAX_MAP_WIDTH));
        repeat (MAX_MAP_WIDTH) send_pixel(SAMPLE_BITS'($urandom()), 1'b0, NO_RES);

        // Random phases: mostly whole small maps with random content
        sent = 0;
        while (sent < RAND_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) k_raw = $urandom_range(1, 4);
            else if (sel < 8) k_raw = $urandom_range(5, 8);
            else k_raw = $urandom_range(0, 15);
            k_eff = clip_reg(k_raw, MAX_WINDOW);

            sel = $urandom_range(0, 9);
            if (sel < 7) w_raw = k_eff * $urandom_range(1, 4);
            else if (sel == 7) w_raw = $urandom_range(0, 20);
            else if (sel == 8) w_raw = $urandom_range(40, MAX_MAP_WIDTH);
            else w_raw = $urandom_range(MAX_MAP_WIDTH + 1, 511);
            w_eff = clip_reg(w_raw, MAX_MAP_WIDTH);

            sel = $urandom_range(0, 9);
            if (sel < 8) m_raw = $urandom_range(1, 3);
            else if (sel == 8) m_raw = 0;
            else m_raw = $urandom_range(4, 511);

            write_reg(mpa_pkg::CFG_WINDOW_SIZE, {5'($urandom_range(0, 31)), 4'(k_raw)});
            write_reg(mpa_pkg::CFG_MAP_WIDTH, CFG_DATA_BITS'(w_raw));
            write_reg(mpa_pkg::CFG_MAP_COUNT, CFG_DATA_BITS'(m_raw));

            if (w_eff <= 16) span = w_eff * w_eff * $urandom_range(1, 3);
            else span = $urandom_range(30, 200);
            // keep the total close to the planned item count
            if (span > RAND_ITEMS - sent) span = RAND_ITEMS - sent;

            repeat (span) begin
                // hold a calm stretch with no idling on either side
                gap_pct = (sent >= 300 && sent < 550) ? 0 : IDLE_PCT;
                sel = $urandom_range(0, 9);
                if (sel < 3) px = SAMPLE_BITS'($urandom_range(0, 4)) - SAMPLE_BITS'(2);
                else if (sel == 3) px = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                else px = SAMPLE_BITS'($urandom());
                send_pixel(px, 1'b0, NO_RES);
                sent = sent + 1;
            end
        end

        drain_results();
        if (errors == 0) begin
            $display("max_pool_argmax_stream verification clean");
        end else begin
            $display("max_pool_argmax_stream verification failed");
        end
        $finish;
    end

endmodule
